FILE: rtl/hprc_pkg.sv
// ---------------------------------------------------------------------------
// Route compute package
// Field widths, flit kind codes, register indexes and pipeline item types.
// ---------------------------------------------------------------------------
package hprc_pkg;

    localparam int KIND_W     = 3;
    localparam int NODE_W     = 9;
    localparam int HOP_W      = 3;
    localparam int PORT_W     = 6;
    localparam int VC_W       = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;
    localparam int RATIO_W    = 5;
    localparam int RATIOS     = 4;
    localparam int GRP_W      = 13;
    localparam int PROD_W     = 17;
    localparam int CNT_W      = 20;
    localparam int MP_W       = 10;
    localparam int NODE_MAX   = 1023;

    localparam logic [KIND_W-1:0] KIND_RD_REQ = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RD_REP = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WR_REQ = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WR_REP = 3'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO0 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO1 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO2 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO3 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VCS    = 4'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [HOP_W-1:0]  hops;
        logic              inject;
    } flit_t;

    typedef struct packed {
        logic              inject;
        logic              same;
        logic              req;
        logic [HOP_W-1:0]  hops;
        logic [VC_W-1:0]   vc_first;
        logic [VC_W-1:0]   vc_last;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [NODE_W-1:0] sp;
        logic [NODE_W-1:0] dp;
        logic [PORT_W-1:0] rem_lo;
    } side2_t;

endpackage

FILE: rtl/hprc_div_pipe.sv
// ---------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per register stage.
// ---------------------------------------------------------------------------
module hprc_div_pipe #(
    parameter int DW = 9,
    parameter int RW = 17
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] num_i,
    input  logic [RW-1:0] den_i,
    output logic [DW-1:0] quo_o,
    output logic [RW-1:0] rem_o
);

    logic [DW-1:0] num_reg [DW];
    logic [RW-1:0] den_reg [DW];
    logic [RW-1:0] rem_reg [DW];
    logic [DW-1:0] quo_reg [DW];

    logic [DW-1:0] num_src [DW];
    logic [RW-1:0] den_src [DW];
    logic [RW-1:0] rem_src [DW];
    logic [DW-1:0] quo_src [DW];
    logic [RW:0]   trial   [DW];
    logic [DW-1:0] fit;

    always_comb begin
        for (int s = 0; s < DW; s++) begin
            if (s == 0) begin
                num_src[s] = num_i;
                den_src[s] = den_i;
                rem_src[s] = '0;
                quo_src[s] = '0;
            end else begin
                num_src[s] = num_reg[s-1];
                den_src[s] = den_reg[s-1];
                rem_src[s] = rem_reg[s-1];
                quo_src[s] = quo_reg[s-1];
            end
            trial[s] = {rem_src[s], num_src[s][DW-1]};
            fit[s]   = (trial[s] >= {1'b0, den_src[s]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DW; s++) begin
                num_reg[s] <= {num_src[s][DW-2:0], 1'b0};
                den_reg[s] <= den_src[s];
                rem_reg[s] <= fit[s] ? (trial[s][RW-1:0] - den_src[s]) : trial[s][RW-1:0];
                quo_reg[s] <= {quo_src[s][DW-2:0], fit[s]};
            end
        end
    end

    assign quo_o = quo_reg[DW-1];
    assign rem_o = rem_reg[DW-1];

endmodule

FILE: rtl/hierarchical_partition_route_compute.sv
// ---------------------------------------------------------------------------
// Hierarchical partition route compute
// Gives output port, virtual-channel range and error flag for each head flit.
// ---------------------------------------------------------------------------
//  Channel  | Ports                                   | Direction
//  ---------+-----------------------------------------+----------
//  flit in  | s_valid s_ready s_flit_kind ... s_injecting | in
//  route out| m_valid m_ready m_any_port ... m_route_error| out
//  config   | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// One item per cycle while the result is taken; each item passes 15 entry stages
// and two chained 9-stage divider pipelines plus the output register.
// Derived configuration (the slice-per-partition division) settles through the
// product registers and the divider after a write, which the entry stages cover.
// Reset clears the valid bits, sets the registers to their reset values and
// holds both ready outputs low.
// A result that is not taken holds the whole pipeline and drops s_ready.
// ---------------------------------------------------------------------------
module hierarchical_partition_route_compute #(
    parameter int MAX_LAYERS = 4,
    parameter int MAX_NODES  = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [hprc_pkg::KIND_W-1:0]      s_flit_kind,
    input  logic [hprc_pkg::NODE_W-1:0]      s_source_node,
    input  logic [hprc_pkg::NODE_W-1:0]      s_target_node,
    input  logic [hprc_pkg::HOP_W-1:0]       s_hop_count,
    input  logic                             s_injecting,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hprc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hprc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_any_port,
    output logic [hprc_pkg::PORT_W-1:0]      m_egress_port,
    output logic [hprc_pkg::VC_W-1:0]        m_vc_first,
    output logic [hprc_pkg::VC_W-1:0]        m_vc_last,
    output logic                             m_route_error
);

    import hprc_pkg::*;

    localparam int LAYER_LIM     = (MAX_LAYERS < RATIOS) ? MAX_LAYERS : RATIOS;
    localparam int NODE_LIM      = (MAX_NODES < NODE_MAX) ? MAX_NODES : NODE_MAX;
    localparam int ENTRY_STAGES  = 15;
    localparam int DIV_STAGES    = NODE_W;

    // Configuration registers.
    logic [2:0]          layer_reg;
    logic [3:0]          part_reg;
    logic [RATIO_W-1:0]  ratio_reg [RATIOS];
    logic [MP_W-1:0]     nodes_reg;
    logic [4:0]          vcs_reg;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_reg <= 3'd2;
            part_reg  <= 4'd1;
            for (int i = 0; i < RATIOS; i++) begin
                ratio_reg[i] <= 5'd1;
            end
            nodes_reg <= 10'd2;
            vcs_reg   <= 5'd2;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LAYERS: layer_reg    <= cfg_data[2:0];
                CFG_PARTS:  part_reg     <= cfg_data[3:0];
                CFG_RATIO0: ratio_reg[0] <= cfg_data[4:0];
                CFG_RATIO1: ratio_reg[1] <= cfg_data[4:0];
                CFG_RATIO2: ratio_reg[2] <= cfg_data[4:0];
                CFG_RATIO3: ratio_reg[3] <= cfg_data[4:0];
                CFG_NODES:  nodes_reg    <= cfg_data;
                CFG_VCS:    vcs_reg      <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Held register values.
    logic [RATIO_W-1:0] u [RATIOS];
    logic [2:0]         l_eff;
    logic [3:0]         p_eff;
    logic [MP_W-1:0]    nodes_eff;
    logic [4:0]         v_eff;

    always_comb begin
        for (int i = 0; i < RATIOS; i++) begin
            u[i] = (ratio_reg[i] == '0) ? 5'd1 : ratio_reg[i];
        end
        if (layer_reg == 3'd0) begin
            l_eff = 3'd1;
        end else if (layer_reg > 3'(LAYER_LIM)) begin
            l_eff = 3'(LAYER_LIM);
        end else begin
            l_eff = layer_reg;
        end
        p_eff     = (part_reg == 4'd0) ? 4'd1 : part_reg;
        nodes_eff = (nodes_reg > 10'(NODE_LIM)) ? 10'(NODE_LIM) : nodes_reg;
        if (vcs_reg < 5'd2) begin
            v_eff = 5'd2;
        end else if (vcs_reg > 5'd16) begin
            v_eff = 5'd16;
        end else begin
            v_eff = vcs_reg;
        end
    end

    // Derived configuration, recomputed every cycle.
    logic [8:0]        g2_reg;
    logic [GRP_W-1:0]  g3_reg;
    logic [PROD_W-1:0] g4_reg;
    logic [PROD_W-1:0] cp_reg;
    logic [CNT_W-1:0]  c_reg;
    logic [9:0]        g2_next;
    logic [GRP_W-1:0]  g3_next;
    logic [PROD_W-1:0] g4_next;
    logic [PROD_W-1:0] cp_next;
    logic [CNT_W-1:0]  c_next;

    always_comb begin
        g2_next = {5'b0, u[0]} * {5'b0, u[1]};
        g3_next = {4'b0, g2_reg} * {8'b0, u[2]};
        g4_next = {4'b0, g3_reg} * {12'b0, u[3]};
        case (l_eff)
            3'd1:    cp_next = {12'b0, u[0]};
            3'd2:    cp_next = {8'b0, g2_reg};
            3'd3:    cp_next = {4'b0, g3_reg};
            default: cp_next = g4_reg;
        endcase
        c_next = {16'b0, p_eff} * {3'b0, cp_reg};
    end

    always_ff @(posedge aclk) begin
        g2_reg <= g2_next[8:0];
        g3_reg <= g3_next;
        g4_reg <= g4_next;
        cp_reg <= cp_next;
        c_reg  <= c_next;
    end

    logic [MP_W-1:0] mp_num;
    logic [MP_W-1:0] mp_quo;
    logic [3:0]      mp_rem;
    logic [MP_W-1:0] mp_eff;

    assign mp_num = ({10'b0, nodes_eff} > c_reg) ? (nodes_eff - c_reg[MP_W-1:0]) : '0;

    hprc_div_pipe #(.DW(MP_W), .RW(4)) u_mp_div (
        .aclk  (aclk),
        .en    (1'b1),
        .num_i (mp_num),
        .den_i (p_eff),
        .quo_o (mp_quo),
        .rem_o (mp_rem)
    );

    assign mp_eff = (mp_quo == '0) ? 10'd1 : mp_quo;

    logic [GRP_W-1:0] grp [RATIOS];

    assign grp[0] = 13'd1;
    assign grp[1] = {8'b0, u[0]};
    assign grp[2] = {4'b0, g2_reg};
    assign grp[3] = g3_reg;

    // Item pipeline.
    logic pipe_en;
    logic m_valid_reg;

    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en && aresetn;

    flit_t                   ent_reg [ENTRY_STAGES];
    logic [ENTRY_STAGES-1:0] ent_valid_reg;
    flit_t                   flit_in;

    assign flit_in = '{kind: s_flit_kind, src: s_source_node, dst: s_target_node,
                       hops: s_hop_count, inject: s_injecting};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
        end else if (pipe_en) begin
            ent_valid_reg <= {ent_valid_reg[ENTRY_STAGES-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ent_reg[0] <= flit_in;
            for (int k = 1; k < ENTRY_STAGES; k++) begin
                ent_reg[k] <= ent_reg[k-1];
            end
        end
    end

    flit_t             f;
    logic              src_low;
    logic              dst_low;
    logic [NODE_W-1:0] da_num;
    logic [NODE_W-1:0] db_num;
    logic [PROD_W-1:0] da_den;
    logic [PROD_W-1:0] db_den;
    side_t             side_in;
    logic [3:0]        half;

    always_comb begin
        f       = ent_reg[ENTRY_STAGES-1];
        src_low = {11'b0, f.src} < c_reg;
        dst_low = {11'b0, f.dst} < c_reg;
        da_num  = src_low ? f.src : (f.src - c_reg[NODE_W-1:0]);
        da_den  = src_low ? cp_reg : {7'b0, mp_eff};
        db_num  = src_low ? (f.dst - c_reg[NODE_W-1:0]) : f.dst;
        db_den  = src_low ? {7'b0, mp_eff} : cp_reg;
        half    = v_eff[4:1];
        side_in.inject = f.inject;
        side_in.same   = (src_low == dst_low);
        side_in.req    = src_low;
        side_in.hops   = f.hops;
        case (f.kind)
            KIND_RD_REQ, KIND_RD_REP: begin
                side_in.vc_first = 4'd0;
                side_in.vc_last  = half - 4'd1;
            end
            KIND_WR_REQ, KIND_WR_REP: begin
                side_in.vc_first = half;
                side_in.vc_last  = v_eff[3:0] - 4'd1;
            end
            default: begin
                side_in.vc_first = 4'd0;
                side_in.vc_last  = v_eff[3:0] - 4'd1;
            end
        endcase
    end

    logic [NODE_W-1:0]  sp_quo;
    logic [NODE_W-1:0]  dp_quo;
    logic [PROD_W-1:0]  sp_rem;
    logic [PROD_W-1:0]  dp_rem;
    logic [NODE_W-1:0]  q1 [RATIOS];
    logic [GRP_W-1:0]   r1 [RATIOS];
    logic [NODE_W-1:0]  q2 [RATIOS];
    logic [RATIO_W-1:0] digit [RATIOS];

    hprc_div_pipe #(.DW(NODE_W), .RW(PROD_W)) u_sp_div (
        .aclk  (aclk),
        .en    (pipe_en),
        .num_i (da_num),
        .den_i (da_den),
        .quo_o (sp_quo),
        .rem_o (sp_rem)
    );

    hprc_div_pipe #(.DW(NODE_W), .RW(PROD_W)) u_dp_div (
        .aclk  (aclk),
        .en    (pipe_en),
        .num_i (db_num),
        .den_i (db_den),
        .quo_o (dp_quo),
        .rem_o (dp_rem)
    );

    for (genvar i = 0; i < RATIOS; i++) begin : g_digit
        hprc_div_pipe #(.DW(NODE_W), .RW(GRP_W)) u_grp_div (
            .aclk  (aclk),
            .en    (pipe_en),
            .num_i (f.dst),
            .den_i (grp[i]),
            .quo_o (q1[i]),
            .rem_o (r1[i])
        );
        hprc_div_pipe #(.DW(NODE_W), .RW(RATIO_W)) u_ratio_div (
            .aclk  (aclk),
            .en    (pipe_en),
            .num_i (q1[i]),
            .den_i (u[i]),
            .quo_o (q2[i]),
            .rem_o (digit[i])
        );
    end

    side_t                 sb1_reg [DIV_STAGES];
    side2_t                sb2_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] v1_reg;
    logic [DIV_STAGES-1:0] v2_reg;
    side2_t                sb2_in;

    assign sb2_in = '{side: sb1_reg[DIV_STAGES-1], sp: sp_quo, dp: dp_quo,
                      rem_lo: dp_rem[PORT_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= '0;
            v2_reg <= '0;
        end else if (pipe_en) begin
            v1_reg <= {v1_reg[DIV_STAGES-2:0], ent_valid_reg[ENTRY_STAGES-1]};
            v2_reg <= {v2_reg[DIV_STAGES-2:0], v1_reg[DIV_STAGES-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sb1_reg[0] <= side_in;
            sb2_reg[0] <= sb2_in;
            for (int k = 1; k < DIV_STAGES; k++) begin
                sb1_reg[k] <= sb1_reg[k-1];
                sb2_reg[k] <= sb2_reg[k-1];
            end
        end
    end

    // Port selection.
    side2_t             t;
    logic               remote;
    logic [NODE_W-1:0]  dport;
    logic [2:0]         lm1;
    logic [2:0]         total;
    logic signed [4:0]  cur_s;
    logic [2:0]         cur_u;
    logic [PORT_W-1:0]  port;
    logic               any_next;
    logic [PORT_W-1:0]  port_next;
    logic               err_next;

    always_comb begin
        t      = sb2_reg[DIV_STAGES-1];
        remote = (t.sp != t.dp);
        dport  = (t.dp > t.sp) ? (t.dp - 9'd1) : t.dp;
        lm1    = l_eff - 3'd1;
        total  = l_eff + {2'b0, remote};
        cur_s  = $signed({2'b0, total}) - $signed({2'b0, t.side.hops}) - 5'sd1;
        cur_u  = (cur_s < 0) ? 3'd0 : cur_s[2:0];
        if (t.side.req) begin
            if (t.side.hops < lm1) begin
                port = '0;
            end else if (remote && (t.side.hops == lm1)) begin
                port = mp_eff[PORT_W-1:0] + dport[PORT_W-1:0];
            end else begin
                port = t.rem_lo;
            end
        end else begin
            if (cur_u < lm1) begin
                port = {1'b0, digit[cur_u[1:0]]};
            end else if (remote && (cur_u == l_eff)) begin
                port = {1'b0, u[lm1[1:0]]} + dport[PORT_W-1:0];
            end else begin
                port = {1'b0, digit[lm1[1:0]]};
            end
        end
        if (t.side.inject) begin
            any_next  = 1'b1;
            port_next = '0;
            err_next  = 1'b0;
        end else if (t.side.same) begin
            any_next  = 1'b0;
            port_next = '0;
            err_next  = 1'b1;
        end else begin
            any_next  = 1'b0;
            port_next = port;
            err_next  = 1'b0;
        end
    end

    logic              any_reg;
    logic [PORT_W-1:0] port_reg;
    logic [VC_W-1:0]   vcf_reg;
    logic [VC_W-1:0]   vcl_reg;
    logic              err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= v2_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            any_reg  <= any_next;
            port_reg <= port_next;
            vcf_reg  <= t.side.vc_first;
            vcl_reg  <= t.side.vc_last;
            err_reg  <= err_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_any_port    = any_reg;
    assign m_egress_port = port_reg;
    assign m_vc_first    = vcf_reg;
    assign m_vc_last     = vcl_reg;
    assign m_route_error = err_reg;

`ifndef ASSERT_OFF
    a_inject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_any_port |-> (m_egress_port == '0) && !m_route_error)
        else $error("injected item carries a port or an error");

    a_error_port: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_route_error |-> (m_egress_port == '0) && !m_any_port)
        else $error("route error with a port");

    a_vc_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_vc_first <= m_vc_last))
        else $error("empty virtual-channel range");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input held without an output stall");
`endif

endmodule

FILE: bench/hierarchical_partition_route_compute_test.sv
// ---------------------------------------------------------------------------
// Route compute regression bench
// Drives head flits through the route compute stage under several register
// settings, predicts each route, virtual-channel range and error flag, and
// checks every result in order while both sides idle and stall at random.
// ---------------------------------------------------------------------------
module hierarchical_partition_route_compute_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hprc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_OTHER     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd6;
    localparam logic [KIND_W-1:0] KIND_OTHER_TOP = 3'd7;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 75;
    localparam int PHASES       = 12;

    typedef struct packed {
        logic              any_port;
        logic [PORT_W-1:0] egress_port;
        logic [VC_W-1:0]   vc_first;
        logic [VC_W-1:0]   vc_last;
        logic              route_error;
    } route_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        int                src;
        int                dst;
        int                hops;
        bit                inject;
        bit                known;
        route_t            res;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [KIND_W-1:0]     s_flit_kind;
    logic [NODE_W-1:0]     s_source_node;
    logic [NODE_W-1:0]     s_target_node;
    logic [HOP_W-1:0]      s_hop_count;
    logic                  s_injecting;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_any_port;
    logic [PORT_W-1:0]     m_egress_port;
    logic [VC_W-1:0]       m_vc_first;
    logic [VC_W-1:0]       m_vc_last;
    logic                  m_route_error;

    int reg_layers, reg_parts, reg_nodes, reg_vcs;
    int reg_ratio[RATIOS];

    route_t route_expect[$];
    row_t   dir_rows[$];
    int     failures, flits_sent, routes_seen, error_routes, stall_count;
    bit     tx_idle, rx_idle, hold_long;

    hierarchical_partition_route_compute dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int ratio_eff(int i);
        if (i < 0 || i > 3) return 1;
        return (reg_ratio[i] == 0) ? 1 : reg_ratio[i];
    endfunction

    function automatic int layers_eff();
        int l;
        l = reg_layers;
        if (l < 1) l = 1;
        if (l > 4) l = 4;
        return l;
    endfunction

    function automatic int compute_span();
        int prod, i;
        prod = 1;
        for (i = 0; i < layers_eff(); i++) prod *= ratio_eff(i);
        return prod * ((reg_parts == 0) ? 1 : reg_parts);
    endfunction

    function automatic route_t predict_route(logic [KIND_W-1:0] kind, int src, int dst,
                                             int hops, bit inj);
        int v, l, p, nodes, prod, c, cp, mp, sp, dp, total, cur, port, dport, grp, i;
        bit req, remote;
        route_t r;
        v = reg_vcs;
        if (v < 2) v = 2;
        if (v > 16) v = 16;
        if (kind == KIND_RD_REQ || kind == KIND_RD_REP) begin
            r.vc_first = '0;
            r.vc_last  = VC_W'(v / 2 - 1);
        end else if (kind == KIND_WR_REQ || kind == KIND_WR_REP) begin
            r.vc_first = VC_W'(v / 2);
            r.vc_last  = VC_W'(v - 1);
        end else begin
            r.vc_first = '0;
            r.vc_last  = VC_W'(v - 1);
        end
        r.any_port = inj;
        r.egress_port = '0;
        r.route_error = 1'b0;
        if (inj) return r;
        l = layers_eff();
        p = (reg_parts == 0) ? 1 : reg_parts;
        nodes = (reg_nodes > 512) ? 512 : reg_nodes;
        prod = 1;
        for (i = 0; i < l; i++) prod *= ratio_eff(i);
        cp = prod;
        c = p * prod;
        mp = (nodes > c) ? (nodes - c) / p : 0;
        if (mp < 1) mp = 1;
        if ((src < c) == (dst < c)) begin
            r.route_error = 1'b1;
            return r;
        end
        req = src < c;
        sp = req ? src / cp : (src - c) / mp;
        dp = req ? (dst - c) / mp : dst / cp;
        remote = sp != dp;
        total = remote ? l + 1 : l;
        cur = req ? hops : total - hops - 1;
        dport = (dp > sp) ? dp - 1 : dp;
        if (req) begin
            if (cur < l - 1) port = 0;
            else if (remote && cur == total - 2) port = mp + dport;
            else port = (dst - c) % mp;
        end else begin
            if (cur < 0) cur = 0;
            if (cur < l - 1) begin
                grp = 1;
                for (i = 0; i < cur; i++) grp *= ratio_eff(i);
                port = (dst % (grp * ratio_eff(cur))) / grp;
            end else if (remote && cur == total - 1) begin
                port = ratio_eff(l - 1) + dport;
            end else begin
                port = (dst % cp) / (cp / ratio_eff(l - 1));
            end
        end
        r.egress_port = port[PORT_W-1:0];
        return r;
    endfunction

    function automatic row_t mk_row(logic [KIND_W-1:0] kind, int src, int dst, int hops,
                                    bit inj, bit known, bit any, int port, int vf, int vl,
                                    bit err);
        row_t w;
        w.kind = kind; w.src = src; w.dst = dst; w.hops = hops; w.inject = inj;
        w.known = known;
        w.res.any_port = any; w.res.egress_port = PORT_W'(port);
        w.res.vc_first = VC_W'(vf);
        w.res.vc_last = VC_W'(vl); w.res.route_error = err;
        return w;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LAYERS: reg_layers   = value & 7;
            CFG_PARTS:  reg_parts    = value & 15;
            CFG_RATIO0: reg_ratio[0] = value & 31;
            CFG_RATIO1: reg_ratio[1] = value & 31;
            CFG_RATIO2: reg_ratio[2] = value & 31;
            CFG_RATIO3: reg_ratio[3] = value & 31;
            CFG_NODES:  reg_nodes    = value & 1023;
            CFG_VCS:    reg_vcs      = value & 31;
            default: ;
        endcase
    endtask

    task automatic write_setting(int l, int p, int r0, int r1, int r2, int r3, int n, int v);
        write_reg(CFG_LAYERS, l);
        write_reg(CFG_PARTS, p);
        write_reg(CFG_RATIO0, r0);
        write_reg(CFG_RATIO1, r1);
        write_reg(CFG_RATIO2, r2);
        write_reg(CFG_RATIO3, r3);
        write_reg(CFG_NODES, n);
        write_reg(CFG_VCS, v);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_flit(logic [KIND_W-1:0] kind, int src, int dst, int hops, bit inj,
                             bit known, route_t res);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_flit_kind   <= kind;
        s_source_node <= src[NODE_W-1:0];
        s_target_node <= dst[NODE_W-1:0];
        s_hop_count   <= hops[HOP_W-1:0];
        s_injecting   <= inj;
        do @(posedge aclk); while (!s_ready);
        route_expect.insert(route_expect.size(),
                            known ? res : predict_route(kind, src, dst, hops, inj));
        flits_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (route_expect.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_flit();
        int c, nodes, lo_top, hi_lo, hi_top, a, b, hops;
        logic [KIND_W-1:0] kind;
        route_t none;
        none = '0;
        c = compute_span();
        nodes = (reg_nodes > 512) ? 512 : reg_nodes;
        lo_top = (c > 512 ? 512 : c) - 1;
        hi_lo  = (c > 511) ? 511 : c;
        hi_top = nodes - 1;
        kind = KIND_W'($urandom_range(0, 7));
        hops = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 4);
        if ($urandom_range(0, 4) == 0 || c > 511 || hi_top < hi_lo) begin
            send_flit(kind, $urandom_range(0, 511), $urandom_range(0, 511),
                      $urandom_range(0, 7), $urandom_range(0, 1), 1'b0, none);
        end else begin
            a = $urandom_range(0, lo_top);
            b = $urandom_range(hi_lo, hi_top);
            if (kind[0]) send_flit(kind, b, a, hops, $urandom_range(0, 9) == 0, 1'b0, none);
            else         send_flit(kind, a, b, hops, $urandom_range(0, 9) == 0, 1'b0, none);
        end
    endtask

    initial begin
        int ph, n, l, p, r0, r1, r2, r3, c;
        route_t none;
        none = '0;
        aresetn = 1'b0;
        s_valid = 1'b0; s_flit_kind = '0; s_source_node = '0; s_target_node = '0;
        s_hop_count = '0; s_injecting = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        m_ready = 1'b0;
        failures = 0; flits_sent = 0; routes_seen = 0; error_routes = 0;
        tx_idle = 1; rx_idle = 1; hold_long = 0;
        reg_layers = 2; reg_parts = 1; reg_nodes = 2; reg_vcs = 2;
        foreach (reg_ratio[i]) reg_ratio[i] = 1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: one compute node below, one slice above, two channels.
        dir_rows.insert(dir_rows.size(), mk_row(KIND_RD_REQ, 0, 1, 0, 1, 1, 1, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_WR_REQ, 511, 511, 7, 1, 1, 1, 0, 1, 1, 0));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_OTHER, 5, 5, 3, 1, 1, 1, 0, 0, 1, 0));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_OTHER_TOP, 0, 0, 0, 0, 1, 0, 0, 0, 1, 1));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_RD_REP, 100, 200, 0, 0, 1, 0, 0, 0, 0, 1));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_WR_REP, 300, 511, 5, 0, 1, 0, 0, 1, 1, 1));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_RD_REQ, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_RD_REQ, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_WR_REQ, 0, 1, 7, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_RD_REP, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_RD_REP, 1, 0, 7, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_WR_REP, 511, 0, 2, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_SPARE_LO, 0, 511, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk_row(KIND_SPARE_HI, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        foreach (dir_rows[i])
            send_flit(dir_rows[i].kind, dir_rows[i].src, dir_rows[i].dst, dir_rows[i].hops,
                      dir_rows[i].inject, dir_rows[i].known, dir_rows[i].res);
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: write_setting(4, 8, 16, 16, 16, 16, 512, 16);
                1: write_setting(0, 0, 0, 0, 0, 0, 0, 0);
                2: write_setting(7, 15, 31, 31, 31, 31, 1023, 31);
                3: write_setting(1, 1, 1, 16, 16, 16, 512, 16);
                4: write_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
                                 $urandom_range(0, 1023), $urandom_range(0, 1023),
                                 $urandom_range(0, 1023), $urandom_range(0, 1023),
                                 $urandom_range(0, 1023), $urandom_range(0, 1023));
                default: begin
                    l = $urandom_range(1, 4);
                    p = $urandom_range(1, 8);
                    r0 = $urandom_range(1, (l > 2) ? 3 : 4);
                    r1 = $urandom_range(1, (l > 2) ? 3 : 4);
                    r2 = $urandom_range(1, 3);
                    r3 = $urandom_range(1, 3);
                    c = p * r0 * (l > 1 ? r1 : 1) * (l > 2 ? r2 : 1) * (l > 3 ? r3 : 1);
                    n = c + p * $urandom_range(1, 8) + $urandom_range(0, p - 1);
                    if (n > 1023) n = 1023;
                    write_setting(l, p, r0, r1, r2, r3, n, $urandom_range(2, 16));
                end
            endcase
            tx_idle = (ph % 4) != 2;
            rx_idle = (ph % 4) != 3;
            if (ph == 6) hold_long = 1;
            for (n = 0; n < PHASE_ITEMS; n++) random_flit();
            drain();
        end

        $display("Covered %0d flits over %0d register settings, %0d results checked,",
                 flits_sent, PHASES + 1, routes_seen);
        $display("%0d of them same-side errors, with random idling and one long stall.",
                 error_routes);
        if (failures == 0)
            $display("hierarchical_partition_route_compute regression: pass");
        else
            $display("hierarchical_partition_route_compute regression: fail");
        $finish;
    end

    initial begin
        int stall;
        route_t want;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 15) : 0;
            if (hold_long) begin
                stall = LONG_HOLD;
                hold_long = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            routes_seen++;
            if (m_route_error) error_routes++;
            if (route_expect.size() == 0) begin
                $display("%0t: result with nothing expected, got %h/%h/%h/%h/%h", $realtime,
                         m_any_port, m_egress_port, m_vc_first, m_vc_last, m_route_error);
                failures++;
            end else begin
                want = route_expect.pop_front();
                if (m_any_port !== want.any_port) begin
                    $display("%0t: any_port expected %h got %h", $realtime,
                             want.any_port, m_any_port);
                    failures++;
                end
                if (m_egress_port !== want.egress_port) begin
                    $display("%0t: egress_port expected %0d got %0d", $realtime,
                             want.egress_port, m_egress_port);
                    failures++;
                end
                if (m_vc_first !== want.vc_first) begin
                    $display("%0t: vc_first expected %0d got %0d", $realtime,
                             want.vc_first, m_vc_first);
                    failures++;
                end
                if (m_vc_last !== want.vc_last) begin
                    $display("%0t: vc_last expected %0d got %0d", $realtime,
                             want.vc_last, m_vc_last);
                    failures++;
                end
                if (m_route_error !== want.route_error) begin
                    $display("%0t: route_error expected %h got %h", $realtime,
                             want.route_error, m_route_error);
                    failures++;
                end
            end
        end
    end

    initial begin
        stall_count = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                    || aresetn !== 1'b1)
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $realtime, STALL_LIMIT, route_expect.size());
                $display("hierarchical_partition_route_compute regression: fail");
                $finish;
            end
        end
    end

endmodule
